// ----- rtl/bsh_pkg.sv -----
// shared types, constants and helper functions for the byte stream hash
// no dependencies
package bsh_pkg;

   localparam int unsigned HASH_W       = 64;
   localparam int unsigned SHIFT_NARROW = 15;
   localparam int unsigned SHIFT_WIDE   = 31;
   localparam int unsigned SHIFT_MIX    = 6;
   localparam int unsigned SHIFT_BYTE   = 7;
   localparam int unsigned SHIFT_FIN_A  = 3;
   localparam int unsigned SHIFT_FIN_X  = 11;
   localparam int unsigned SHIFT_FIN_B  = 15;

   localparam logic [HASH_W-1:0] MASK_NARROW = 64'h0000_0000_FFFF_FFFF;
   localparam logic [HASH_W-1:0] MASK_WIDE   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [7:0]        first_rev;
      logic              wide;
   } fin_item_type;

   function automatic logic [HASH_W-1:0] mask_for(input logic wide);
      return wide ? MASK_WIDE : MASK_NARROW;
   endfunction

   function automatic logic [7:0] bit_rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[7-k] = b[k];
      end
      return r;
   endfunction

endpackage

// ----- rtl/bsh_round.sv -----
// per-byte round: mode register, running hash state and the add/xor update
// depends on bsh_pkg
module bsh_round
   import bsh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic         csr_write_data,
   input  logic         req_valid,
   input  logic         req_stall,
   input  logic [7:0]   req_data_byte,
   input  logic         req_last_byte,
   output logic         fin_valid,
   output fin_item_type fin_item
);

   logic              wide_ff;
   logic              mid_ff;
   logic              mid_in;
   logic [HASH_W-1:0] hash_ff;
   logic [7:0]        first_rev_ff;
   logic              accept;
   logic [HASH_W-1:0] mask;
   logic [7:0]        rev_in;
   logic [7:0]        first_rev_use;
   logic [HASH_W-1:0] h_start;
   logic [HASH_W-1:0] h_shift;
   logic [HASH_W-1:0] h_sum;
   logic [HASH_W-1:0] h_round;

   always_comb begin
      accept        = req_valid && !req_stall;
      mask          = mask_for(wide_ff);
      rev_in        = bit_rev8(req_data_byte);
      h_start       = mid_ff ? (hash_ff & mask) : {56'd0, rev_in};
      first_rev_use = mid_ff ? first_rev_ff : rev_in;
      h_shift       = wide_ff ? (h_start >> SHIFT_WIDE) : (h_start >> SHIFT_NARROW);
      h_sum         = (h_start + ({49'd0, req_data_byte, 7'd0} | h_shift)) & mask;
      h_round       = h_sum ^ (h_sum >> SHIFT_MIX);
      mid_in        = accept ? !req_last_byte : mid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b0;
         mid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            wide_ff <= csr_write_data;
         end
         mid_ff <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hash_ff      <= h_round;
         first_rev_ff <= first_rev_use;
      end
   end

   assign fin_valid          = accept && req_last_byte;
   assign fin_item.hash      = h_round;
   assign fin_item.first_rev = first_rev_use;
   assign fin_item.wide      = wide_ff;

`ifndef SYNTH
   a_last_ends_message: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> !mid_ff)
      else $error("message still open after last item");
   a_round_narrow: assert property (@(posedge clock) disable iff (reset)
      !wide_ff |-> h_round[63:32] == 32'd0)
      else $error("narrow round leaked into upper bits");
`endif

endmodule

// ----- rtl/bsh_final.sv -----
// finalization pipeline: round result register, add/xor stage, output register
// depends on bsh_pkg
module bsh_final
   import bsh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fin_valid,
   input  fin_item_type fin_item,
   output logic         in_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_digest
);

   logic              v1_ff, v2_ff, v3_ff;
   logic              v1_in, v2_in, v3_in;
   fin_item_type      s1_ff;
   fin_item_type      s2_ff;
   fin_item_type      s2_in;
   logic [HASH_W-1:0] dig_ff;
   logic [HASH_W-1:0] dig_in;
   logic              wide3_ff;
   logic              move1, move2, move3;
   logic [HASH_W-1:0] m1, m2, a1;

   always_comb begin
      move3 = !v3_ff || !rsp_stall;
      move2 = !v2_ff || move3;
      move1 = !v1_ff || move2;
      in_stall = !move1;

      m1 = mask_for(s1_ff.wide);
      a1 = (s1_ff.hash + (s1_ff.hash << SHIFT_FIN_A)) & m1;
      s2_in.hash      = a1 ^ (a1 >> SHIFT_FIN_X);
      s2_in.first_rev = s1_ff.first_rev;
      s2_in.wide      = s1_ff.wide;

      m2 = mask_for(s2_ff.wide);
      dig_in = (s2_ff.hash + (s2_ff.hash << SHIFT_FIN_B) + {56'd0, s2_ff.first_rev}) & m2;

      v1_in = move1 ? fin_valid : v1_ff;
      v2_in = move2 ? v1_ff : v2_ff;
      v3_in = move3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         s1_ff <= fin_item;
      end
      if (move2) begin
         s2_ff <= s2_in;
      end
      if (move3) begin
         dig_ff   <= dig_in;
         wide3_ff <= s2_ff.wide;
      end
   end

   assign rsp_valid  = v3_ff;
   assign rsp_digest = dig_ff;

`ifndef SYNTH
   a_narrow_digest: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !wide3_ff |-> dig_ff[63:32] == 32'd0)
      else $error("narrow digest has upper bits set");
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      in_stall |-> v1_ff && v2_ff && v3_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");
   a_stage2_held: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !move3 |=> v2_ff && $stable(s2_ff))
      else $error("blocked stage two lost its item");
`endif

endmodule

// ----- rtl/byte_stream_hash_32_64.sv -----
// byte stream hash, 32-bit or 64-bit, one message byte per item
// a last item accepted passes the round result, add/xor and output registers before its digest shows on rsp_valid
// throughput: one item per cycle while req_stall is low; the running hash round fits in the accept cycle
// finalization runs in a three-register pipeline that holds up to three digests
// reset is synchronous, active high: 32-bit mode, pipeline empty, awaiting first byte
// depends on bsh_pkg, bsh_round, bsh_final
module byte_stream_hash_32_64
   import bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest
);

   logic         fin_valid;
   fin_item_type fin_item;

   bsh_round u_round (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .fin_valid        (fin_valid),
      .fin_item         (fin_item)
   );

   bsh_final u_final (
      .clock      (clock),
      .reset      (reset),
      .fin_valid  (fin_valid),
      .fin_item   (fin_item),
      .in_stall   (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_digest (rsp_digest)
   );

endmodule
